### src/pcdt_pkg.sv
package pcdt_pkg;

	// Coordinate and field widths
	localparam int CW      = 12;
	localparam int DLT_W   = 16;
	localparam int SUM_W   = DLT_W + 2;
	localparam int OFS_W   = CW + 1;
	localparam int IN_DW   = 24;
	localparam int OUT_DW  = 56;

	// Event kinds carried on s_tuser
	localparam logic [1:0] KIND_MOTION = 2'd0;
	localparam logic [1:0] KIND_BUTTON = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	// Button values and identifiers
	localparam logic [1:0] BVAL_RELEASE = 2'd0;
	localparam logic [1:0] BVAL_PRESS   = 2'd1;
	localparam logic [1:0] BTN_OTHER    = 2'd3;

	// Result kinds carried on m_tuser
	localparam logic [1:0] RES_CLICK    = 2'd0;
	localparam logic [1:0] RES_DRAG     = 2'd1;
	localparam logic [1:0] RES_DRAG_END = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_XLIM   = 2'd1;
	localparam logic [1:0] REG_YLIM   = 2'd2;
	localparam logic [1:0] REG_THRESH = 2'd3;

	// Reset values
	localparam logic [CW-1:0] XLIM_RST   = 12'd1919;
	localparam logic [CW-1:0] YLIM_RST   = 12'd1079;
	localparam logic [CW-1:0] THRESH_RST = 12'd2;
	localparam logic [CW-1:0] CURSOR_RST = 12'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REL_READ,
		ST_REL_EVAL,
		ST_TICK_READ,
		ST_TICK_EVAL,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0]    button;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic          held;
	} entry_t;

	typedef struct packed {
		logic [1:0]            kind;
		logic [1:0]            button;
		logic [CW-1:0]         cx;
		logic [CW-1:0]         cy;
		logic signed [OFS_W-1:0] dx;
		logic signed [OFS_W-1:0] dy;
	} result_t;

	// Commands from the controller
	typedef struct packed {
		logic accept;
		logic walk_start;
		logic walk_read;
		logic rel_step;
		logic tick_step;
		logic tick_close;
		logic flush;
	} cmd_t;

	// Status towards the controller
	typedef struct packed {
		logic start_release;
		logic start_tick;
		logic walk_end;
		logic need_result;
		logic stage_valid;
		logic out_free;
	} sts_t;

endpackage

### src/pointer_click_drag_tracker.sv
// Pointer click and drag tracker.
// Input channel s_*: one transaction per pointer event. s_tuser is the event
// kind (motion, button change, tick); s_tdata carries axis, delta, button
// identifier and button value. Result channel m_*: click, drag-in-progress
// and drag-finished results; m_tlast marks the final result of a tick.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (mode, x limit,
// y limit, drag threshold); write only while the block is idle.
// Per input transaction: motion, press and ignored events need no walk; a
// release and a tick walk the N pending entries of the single-port pending
// store (a read and an evaluate per entry, then a step to see the end of the
// walk and, for a tick, a last step to flush the staged result).
// Results leave through a staging register and an output register; a staged
// result moves on when the next result is staged or at the tick's flush.
// When the receiver stalls, the walk holds on the next entry that yields a
// result; s_tready stays low until the tick's last result sits in the output
// register. Reset restores the default configuration, puts the cursor at
// 100,100 and empties the store; no clearing pass is needed.
module pointer_click_drag_tracker #(
	parameter int PENDING_DEPTH = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pcdt_pkg::IN_DW-1:0]  s_tdata,  // axis, delta, button_id, button_value
	input  logic [1:0]                  s_tuser,  // event_kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pcdt_pkg::OUT_DW-1:0] m_tdata,  // button_out, click_x, click_y,
	                                               // move_dx, move_dy
	output logic [1:0]                  m_tuser,  // result_kind
	output logic                        m_tlast,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_addr,
	input  logic [pcdt_pkg::CW-1:0]     cfg_wdata
);

	pcdt_pkg::cmd_t cmd;
	pcdt_pkg::sts_t sts;

	pcdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcdt_dp #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

### src/pcdt_ctrl.sv
module pcdt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  pcdt_pkg::sts_t  sts,
	output pcdt_pkg::cmd_t  cmd
);

	pcdt_pkg::state_t state_q;
	pcdt_pkg::state_t state_nx;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pcdt_pkg::ST_IDLE: begin
				if (s_tvalid && sts.start_release) begin
					state_nx = pcdt_pkg::ST_REL_READ;
				end else if (s_tvalid && sts.start_tick) begin
					state_nx = pcdt_pkg::ST_TICK_READ;
				end
			end
			pcdt_pkg::ST_REL_READ: begin
				state_nx = sts.walk_end ? pcdt_pkg::ST_IDLE : pcdt_pkg::ST_REL_EVAL;
			end
			pcdt_pkg::ST_REL_EVAL: begin
				state_nx = pcdt_pkg::ST_REL_READ;
			end
			pcdt_pkg::ST_TICK_READ: begin
				state_nx = sts.walk_end ? pcdt_pkg::ST_FLUSH : pcdt_pkg::ST_TICK_EVAL;
			end
			pcdt_pkg::ST_TICK_EVAL: begin
				if (!(sts.need_result && sts.stage_valid && !sts.out_free)) begin
					state_nx = pcdt_pkg::ST_TICK_READ;
				end
			end
			pcdt_pkg::ST_FLUSH: begin
				if (!sts.stage_valid || sts.out_free) begin
					state_nx = pcdt_pkg::ST_IDLE;
				end
			end
			default: state_nx = pcdt_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			pcdt_pkg::ST_IDLE: begin
				s_tready       = 1'b1;
				cmd.accept     = s_tvalid;
				cmd.walk_start = s_tvalid && (sts.start_release || sts.start_tick);
			end
			pcdt_pkg::ST_REL_READ: begin
				cmd.walk_read = !sts.walk_end;
			end
			pcdt_pkg::ST_REL_EVAL: begin
				cmd.rel_step = 1'b1;
			end
			pcdt_pkg::ST_TICK_READ: begin
				cmd.walk_read  = !sts.walk_end;
				cmd.tick_close = sts.walk_end;
			end
			pcdt_pkg::ST_TICK_EVAL: begin
				cmd.tick_step = !(sts.need_result && sts.stage_valid && !sts.out_free);
			end
			pcdt_pkg::ST_FLUSH: begin
				cmd.flush = sts.stage_valid && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### src/pcdt_dp.sv
module pcdt_dp #(
	parameter int PENDING_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcdt_pkg::cmd_t                cmd,
	output pcdt_pkg::sts_t                sts,
	input  logic [pcdt_pkg::IN_DW-1:0]    s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [pcdt_pkg::CW-1:0]       cfg_wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pcdt_pkg::OUT_DW-1:0]   m_tdata,
	output logic [1:0]                    m_tuser,
	output logic                          m_tlast
);

	localparam int CW    = pcdt_pkg::CW;
	localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
	localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

	// Configuration
	logic          mode_q;
	logic [CW-1:0] xlim_q;
	logic [CW-1:0] ylim_q;
	logic [CW-1:0] thresh_q;

	// Cursor and store bookkeeping
	logic [CW-1:0]    cur_x_q;
	logic [CW-1:0]    cur_y_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] keep_q;
	logic [1:0]       rel_btn_q;

	pcdt_pkg::entry_t mem [PENDING_DEPTH];
	pcdt_pkg::entry_t rd_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_addr;
	pcdt_pkg::entry_t  mem_wdata;

	// Result staging and output register
	pcdt_pkg::result_t stage_q;
	logic              stage_valid_q;
	pcdt_pkg::result_t out_q;
	logic              out_valid_q;
	logic              out_last_q;

	// Input fields
	logic [1:0]                    in_kind;
	logic                          in_axis;
	logic signed [pcdt_pkg::DLT_W-1:0] in_delta;
	logic [1:0]                    in_btn;
	logic [1:0]                    in_bval;

	assign in_kind  = s_tuser;
	assign in_axis  = s_tdata[0];
	assign in_delta = signed'(s_tdata[16:1]);
	assign in_btn   = s_tdata[18:17];
	assign in_bval  = s_tdata[20:19];

	// Decode the event
	logic is_motion;
	logic press_ok;

	assign is_motion = (in_kind == pcdt_pkg::KIND_MOTION);
	assign press_ok  = (in_kind == pcdt_pkg::KIND_BUTTON) && !mode_q &&
		(in_bval == pcdt_pkg::BVAL_PRESS) && (in_btn != pcdt_pkg::BTN_OTHER) &&
		(count_q < CNT_W'(PENDING_DEPTH));

	// Clamp the moved axis
	logic [CW-1:0]                   cur_sel;
	logic [CW-1:0]                   lim_sel;
	logic signed [pcdt_pkg::SUM_W-1:0] sum;
	logic [CW-1:0]                   clamped;

	always_comb begin
		cur_sel = in_axis ? cur_y_q : cur_x_q;
		lim_sel = in_axis ? ylim_q : xlim_q;
		sum     = signed'(pcdt_pkg::SUM_W'(cur_sel)) +
			signed'({{(pcdt_pkg::SUM_W-pcdt_pkg::DLT_W){in_delta[pcdt_pkg::DLT_W-1]}},
				in_delta});
		if (sum[pcdt_pkg::SUM_W-1]) begin
			clamped = '0;
		end else if (sum > signed'(pcdt_pkg::SUM_W'(lim_sel))) begin
			clamped = lim_sel;
		end else begin
			clamped = sum[CW-1:0];
		end
	end

	// Evaluate the entry just read
	logic signed [CW:0] dx;
	logic signed [CW:0] dy;
	logic [CW:0]        adx;
	logic [CW:0]        ady;
	logic               moved;
	pcdt_pkg::result_t  res;

	always_comb begin
		dx    = signed'({1'b0, cur_x_q}) - signed'({1'b0, rd_q.ax});
		dy    = signed'({1'b0, cur_y_q}) - signed'({1'b0, rd_q.ay});
		adx   = dx[CW] ? unsigned'(-dx) : unsigned'(dx);
		ady   = dy[CW] ? unsigned'(-dy) : unsigned'(dy);
		moved = (adx > {1'b0, thresh_q}) || (ady > {1'b0, thresh_q});
		res.button = rd_q.button;
		if (rd_q.held) begin
			res.kind = pcdt_pkg::RES_DRAG;
		end else if (moved) begin
			res.kind = pcdt_pkg::RES_DRAG_END;
		end else begin
			res.kind = pcdt_pkg::RES_CLICK;
		end
		if (!rd_q.held && !moved) begin
			res.cx = cur_x_q;
			res.cy = cur_y_q;
			res.dx = '0;
			res.dy = '0;
		end else begin
			res.cx = '0;
			res.cy = '0;
			res.dx = dx;
			res.dy = dy;
		end
	end

	logic need_result;
	logic out_free;
	logic out_load;
	logic stage_load;

	assign need_result = moved || !rd_q.held;
	assign out_free    = !out_valid_q || m_tready;
	assign stage_load  = cmd.tick_step && need_result;
	assign out_load    = (stage_load && stage_valid_q) || cmd.flush;

	// Status
	always_comb begin
		sts.start_release = (in_kind == pcdt_pkg::KIND_BUTTON) && !mode_q &&
			(in_bval == pcdt_pkg::BVAL_RELEASE);
		sts.start_tick    = (in_kind == pcdt_pkg::KIND_TICK);
		sts.walk_end      = (idx_q == count_q);
		sts.need_result   = need_result;
		sts.stage_valid   = stage_valid_q;
		sts.out_free      = out_free;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			xlim_q   <= pcdt_pkg::XLIM_RST;
			ylim_q   <= pcdt_pkg::YLIM_RST;
			thresh_q <= pcdt_pkg::THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				pcdt_pkg::REG_MODE:   mode_q   <= cfg_wdata[0];
				pcdt_pkg::REG_XLIM:   xlim_q   <= cfg_wdata;
				pcdt_pkg::REG_YLIM:   ylim_q   <= cfg_wdata;
				pcdt_pkg::REG_THRESH: thresh_q <= cfg_wdata;
				default: mode_q <= mode_q;
			endcase
		end
	end

	// Cursor, fill count and walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= pcdt_pkg::CURSOR_RST;
			cur_y_q   <= pcdt_pkg::CURSOR_RST;
			count_q   <= '0;
			idx_q     <= '0;
			keep_q    <= '0;
			rel_btn_q <= '0;
		end else begin
			if (cmd.accept && is_motion) begin
				if (in_axis) begin
					cur_y_q <= clamped;
				end else begin
					cur_x_q <= clamped;
				end
			end
			if (cmd.accept && press_ok) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.tick_close) begin
				count_q <= keep_q;
			end
			if (cmd.walk_start) begin
				idx_q     <= '0;
				keep_q    <= '0;
				rel_btn_q <= in_btn;
			end else if (cmd.rel_step) begin
				idx_q <= idx_q + 1'b1;
			end else if (cmd.tick_step) begin
				idx_q <= idx_q + 1'b1;
				if (rd_q.held) begin
					keep_q <= keep_q + 1'b1;
				end
			end
		end
	end

	// Select the single store write
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = idx_q[IDX_W-1:0];
		mem_wdata = rd_q;
		if (cmd.accept && press_ok) begin
			mem_we           = 1'b1;
			mem_addr         = count_q[IDX_W-1:0];
			mem_wdata.button = in_btn;
			mem_wdata.ax     = cur_x_q;
			mem_wdata.ay     = cur_y_q;
			mem_wdata.held   = 1'b1;
		end else if (cmd.rel_step) begin
			mem_we         = 1'b1;
			mem_wdata.held = rd_q.held && (rd_q.button != rel_btn_q);
		end else if (cmd.tick_step && rd_q.held) begin
			mem_we   = 1'b1;
			mem_addr = keep_q[IDX_W-1:0];
			if (moved) begin
				mem_wdata.ax = cur_x_q;
				mem_wdata.ay = cur_y_q;
			end
		end
	end

	// Pending store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (cmd.walk_read) begin
			rd_q <= mem[idx_q[IDX_W-1:0]];
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (stage_load) begin
			stage_q <= res;
		end
		if (out_load) begin
			out_q      <= stage_q;
			out_last_q <= cmd.flush;
		end
	end

	// Stage and output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (stage_load) begin
				stage_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				stage_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_q.dy, out_q.dx, out_q.cy, out_q.cx, out_q.button};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending count beyond store depth");

	a_keep_behind: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= idx_q)
		else $error("compaction pointer ahead of walk pointer");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while still held");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !stage_valid_q)
		else $error("transaction accepted with a result still staged");

endmodule

### tb/pointer_click_drag_tracker_tb.sv
`timescale 1ns / 1ps

module pointer_click_drag_tracker_tb;

	localparam int DEPTH = 8;

	// Button identifiers and codes the package does not name
	localparam logic [1:0] BID_LEFT     = 2'd0;
	localparam logic [1:0] BID_RIGHT    = 2'd1;
	localparam logic [1:0] BID_MIDDLE   = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam logic [1:0] BVAL_JUNK2   = 2'd2;
	localparam logic [1:0] BVAL_JUNK3   = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic        axis;
		logic [15:0] delta;
		logic [1:0]  btn;
		logic [1:0]  bval;
		bit          drain_first;
	} ptr_event_t;

	typedef struct {
		logic [1:0]  kind;
		logic [1:0]  btn;
		logic [11:0] cx;
		logic [11:0] cy;
		logic [12:0] dx;
		logic [12:0] dy;
		logic        last;
	} gesture_t;

	typedef struct {
		logic [1:0] btn;
		int         ax;
		int         ay;
		bit         held;
	} press_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [pcdt_pkg::IN_DW-1:0]    s_tdata;
	logic [1:0]                    s_tuser;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [pcdt_pkg::OUT_DW-1:0]   m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;
	logic                          cfg_we;
	logic [1:0]                    cfg_addr;
	logic [pcdt_pkg::CW-1:0]       cfg_wdata;

	// Tracker model state and configuration
	bit         mdl_mode = 1'b0;
	int         mdl_xlim = pcdt_pkg::XLIM_RST;
	int         mdl_ylim = pcdt_pkg::YLIM_RST;
	int         mdl_thresh = pcdt_pkg::THRESH_RST;
	int         mdl_cx = pcdt_pkg::CURSOR_RST;
	int         mdl_cy = pcdt_pkg::CURSOR_RST;
	press_t     press_tab [DEPTH];
	int         press_cnt = 0;

	ptr_event_t event_q [$];
	gesture_t   gesture_q [$];
	ptr_event_t bus_event;
	int         snd_idle_pct;
	int         rcv_idle_pct;
	int         mismatch_cnt = 0;

	pointer_click_drag_tracker #(
		.PENDING_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int clamp_coord(int v, int lim);
		if (v < 0) return 0;
		if (v > lim) return lim;
		return v;
	endfunction

	// Advance the tracker model by one event; queue the gestures it gives
	function automatic void track_event(ptr_event_t e);
		int       d;
		int       dx;
		int       dy;
		int       keep;
		int       n;
		bit       moved;
		press_t   p;
		gesture_t g;
		n = 0;
		case (e.kind)
			pcdt_pkg::KIND_MOTION: begin
				d = int'($signed(e.delta));
				if (e.axis == 1'b0)
					mdl_cx = clamp_coord(mdl_cx + d, mdl_xlim);
				else
					mdl_cy = clamp_coord(mdl_cy + d, mdl_ylim);
			end
			pcdt_pkg::KIND_BUTTON: begin
				if (!mdl_mode) begin
					if (e.bval == pcdt_pkg::BVAL_RELEASE) begin
						for (int i = 0; i < press_cnt; i++)
							if (press_tab[i].btn == e.btn)
								press_tab[i].held = 1'b0;
					end else if (e.bval == pcdt_pkg::BVAL_PRESS) begin
						if (e.btn != pcdt_pkg::BTN_OTHER && press_cnt < DEPTH) begin
							press_tab[press_cnt] = '{e.btn, mdl_cx, mdl_cy, 1'b1};
							press_cnt++;
						end
					end
				end
			end
			pcdt_pkg::KIND_TICK: begin
				keep = 0;
				for (int i = 0; i < press_cnt; i++) begin
					p = press_tab[i];
					dx = mdl_cx - p.ax;
					dy = mdl_cy - p.ay;
					moved = (dx < 0 ? -dx : dx) > mdl_thresh ||
						(dy < 0 ? -dy : dy) > mdl_thresh;
					g = '{pcdt_pkg::RES_CLICK, p.btn, 12'd0, 12'd0, 13'd0, 13'd0, 1'b0};
					if (p.held) begin
						if (moved) begin
							g.kind = pcdt_pkg::RES_DRAG;
							g.dx = 13'(dx);
							g.dy = 13'(dy);
							gesture_q.push_back(g);
							n++;
							p.ax = mdl_cx;
							p.ay = mdl_cy;
						end
						press_tab[keep] = p;
						keep++;
					end else begin
						if (moved) begin
							g.kind = pcdt_pkg::RES_DRAG_END;
							g.dx = 13'(dx);
							g.dy = 13'(dy);
						end else begin
							g.cx = 12'(mdl_cx);
							g.cy = 12'(mdl_cy);
						end
						gesture_q.push_back(g);
						n++;
					end
				end
				press_cnt = keep;
				if (n > 0)
					gesture_q[gesture_q.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Event with every field random; helpers below override what matters
	function automatic ptr_event_t rand_event();
		ptr_event_t e;
		e.kind = 2'($urandom_range(0, 3));
		e.axis = 1'($urandom);
		e.delta = 16'($urandom);
		e.btn = 2'($urandom);
		e.bval = 2'($urandom);
		e.drain_first = 1'b0;
		return e;
	endfunction

	function automatic void push_motion(logic axis, logic [15:0] delta);
		ptr_event_t e;
		e = rand_event();
		e.kind = pcdt_pkg::KIND_MOTION;
		e.axis = axis;
		e.delta = delta;
		event_q.push_back(e);
	endfunction

	function automatic void push_button(logic [1:0] btn, logic [1:0] bval);
		ptr_event_t e;
		e = rand_event();
		e.kind = pcdt_pkg::KIND_BUTTON;
		e.btn = btn;
		e.bval = bval;
		event_q.push_back(e);
	endfunction

	function automatic void push_tick();
		ptr_event_t e;
		e = rand_event();
		e.kind = pcdt_pkg::KIND_TICK;
		event_q.push_back(e);
	endfunction

	// Motion step sized around the drag threshold, now and then any value
	function automatic logic [15:0] pick_delta();
		int span;
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		span = mdl_thresh + 4;
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	// Fill the event queue with press/move/tick/release runs and some noise
	function automatic void gen_random(int target);
		int         base;
		int         np;
		logic [1:0] pressed [3];
		base = event_q.size();
		while (event_q.size() - base < target) begin
			if ($urandom_range(0, 9) < 7) begin
				np = $urandom_range(1, 3);
				for (int i = 0; i < np; i++) begin
					pressed[i] = 2'($urandom_range(0, 2));
					push_button(pressed[i], pcdt_pkg::BVAL_PRESS);
				end
				if ($urandom_range(0, 14) == 0)
					event_q[event_q.size() - np].drain_first = 1'b1;
				repeat ($urandom_range(0, 4))
					push_motion(1'($urandom), pick_delta());
				if ($urandom_range(0, 1))
					push_tick();
				repeat ($urandom_range(0, 2))
					push_motion(1'($urandom), pick_delta());
				for (int i = 0; i < np; i++)
					if ($urandom_range(0, 3) != 0)
						push_button(pressed[i], pcdt_pkg::BVAL_RELEASE);
				push_tick();
			end else begin
				repeat ($urandom_range(1, 3))
					event_q.push_back(rand_event());
			end
		end
		// hold one event back until the block has delivered everything
		event_q[base + (event_q.size() - base) / 2].drain_first = 1'b1;
	endfunction

	task automatic write_reg(logic [1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= pcdt_pkg::CW'(val);
		case (idx)
			pcdt_pkg::REG_MODE:   mdl_mode = val[0];
			pcdt_pkg::REG_XLIM:   mdl_xlim = val & 12'hFFF;
			pcdt_pkg::REG_YLIM:   mdl_ylim = val & 12'hFFF;
			pcdt_pkg::REG_THRESH: mdl_thresh = val & 12'hFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(int mode, int xl, int yl, int th);
		write_reg(pcdt_pkg::REG_MODE, mode);
		write_reg(pcdt_pkg::REG_XLIM, xl);
		write_reg(pcdt_pkg::REG_YLIM, yl);
		write_reg(pcdt_pkg::REG_THRESH, th);
	endtask

	// Wait for every event taken and every gesture seen, then let the walk settle
	task automatic wait_drained();
		while (event_q.size() != 0 || s_tvalid || gesture_q.size() != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Driver: present queued events, predict each transaction as it is taken
	always @(posedge clk) begin : drive_proc
		bit taken;
		bit go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			taken = s_tvalid && s_tready;
			if (taken)
				track_event(bus_event);
			if (!s_tvalid || taken) begin
				go = event_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct;
				if (go && event_q[0].drain_first && gesture_q.size() != 0)
					go = 1'b0;
				if (go) begin
					bus_event = event_q.pop_front();
					s_tdata <= {3'b000, bus_event.bval, bus_event.btn,
						bus_event.delta, bus_event.axis};
					s_tuser <= bus_event.kind;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= $urandom_range(0, 99) >= rcv_idle_pct;
	end

	// Monitor: compare each result transaction with the oldest predicted gesture
	always @(posedge clk) begin : monitor_proc
		gesture_t g;
		if (arst_n && m_tvalid && m_tready) begin
			if (gesture_q.size() == 0) begin
				$error("unexpected result: kind %0d tdata %h", m_tuser, m_tdata);
				mismatch_cnt++;
			end else begin
				g = gesture_q.pop_front();
				if (m_tuser !== g.kind) begin
					$error("result_kind: expected %0d, got %0d", g.kind, m_tuser);
					mismatch_cnt++;
				end
				if (m_tdata[1:0] !== g.btn) begin
					$error("button_out: expected %0d, got %0d", g.btn, m_tdata[1:0]);
					mismatch_cnt++;
				end
				if (m_tdata[13:2] !== g.cx) begin
					$error("click_x: expected %0d, got %0d", g.cx, m_tdata[13:2]);
					mismatch_cnt++;
				end
				if (m_tdata[25:14] !== g.cy) begin
					$error("click_y: expected %0d, got %0d", g.cy, m_tdata[25:14]);
					mismatch_cnt++;
				end
				if (m_tdata[38:26] !== g.dx) begin
					$error("move_dx: expected %0d, got %0d", $signed(g.dx),
						$signed(m_tdata[38:26]));
					mismatch_cnt++;
				end
				if (m_tdata[51:39] !== g.dy) begin
					$error("move_dy: expected %0d, got %0d", $signed(g.dy),
						$signed(m_tdata[51:39]));
					mismatch_cnt++;
				end
				if (m_tlast !== g.last) begin
					$error("last_result: expected %0d, got %0d", g.last, m_tlast);
					mismatch_cnt++;
				end
			end
		end
	end

	// Stimulus and phase control
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		snd_idle_pct = 11;
		rcv_idle_pct = 52;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset configuration
		push_tick();                                   // nothing pending
		push_motion(1'b0, 16'h8000);                   // clamp to 0
		push_motion(1'b1, 16'h7FFF);                   // clamp to y limit
		push_button(BID_LEFT, pcdt_pkg::BVAL_PRESS);
		push_button(BID_RIGHT, pcdt_pkg::BVAL_PRESS);
		push_button(BID_MIDDLE, pcdt_pkg::BVAL_PRESS);
		push_button(pcdt_pkg::BTN_OTHER, pcdt_pkg::BVAL_PRESS);   // no entry
		push_button(BID_LEFT, BVAL_JUNK2);             // ignored value
		push_button(BID_LEFT, BVAL_JUNK3);
		begin : unknown_kind
			ptr_event_t e;
			e = rand_event();
			e.kind = KIND_UNKNOWN;
			event_q.push_back(e);
		end
		push_motion(1'b0, 16'h7FFF);                   // clamp to x limit
		push_tick();                                   // three drags, re-anchored
		push_button(BID_LEFT, pcdt_pkg::BVAL_RELEASE);
		push_button(BID_LEFT, pcdt_pkg::BVAL_RELEASE); // repeated release
		push_button(pcdt_pkg::BTN_OTHER, pcdt_pkg::BVAL_RELEASE); // matches nothing
		push_tick();                                   // left click
		push_motion(1'b1, 16'h8000);
		push_button(BID_RIGHT, pcdt_pkg::BVAL_RELEASE);
		push_tick();                                   // right drag end, middle drag
		repeat (5) push_button(BID_LEFT, pcdt_pkg::BVAL_PRESS);
		push_button(BID_RIGHT, pcdt_pkg::BVAL_PRESS);
		push_button(BID_MIDDLE, pcdt_pkg::BVAL_PRESS);
		push_button(BID_RIGHT, pcdt_pkg::BVAL_PRESS);  // store full, dropped
		push_button(BID_LEFT, pcdt_pkg::BVAL_RELEASE);
		push_button(BID_RIGHT, pcdt_pkg::BVAL_RELEASE);
		push_button(BID_MIDDLE, pcdt_pkg::BVAL_RELEASE);
		push_tick();                                   // eight results
		gen_random(50);
		wait_drained();

		// Widest limits, zero threshold; finish with the cursor at the far corner
		write_all(0, 4095, 4095, 0);
		gen_random(50);
		push_motion(1'b0, 16'h7FFF);
		push_motion(1'b1, 16'h7FFF);
		wait_drained();

		// Button events ignored; limits lowered below the cursor
		snd_idle_pct = 52;
		rcv_idle_pct = 11;
		write_all(1, 0, 0, 4095);
		push_tick();
		gen_random(50);
		wait_drained();

		write_all(0, $urandom_range(1, 4095), $urandom_range(1, 4095),
			$urandom_range(0, 15));
		gen_random(50);
		wait_drained();

		// No idling on either side
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		write_all(0, pcdt_pkg::XLIM_RST, pcdt_pkg::YLIM_RST, pcdt_pkg::THRESH_RST);
		gen_random(50);
		wait_drained();

		write_all(0, 4095, 0, 1);
		gen_random(50);
		wait_drained();

		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Run limit
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
